>>> rtl/bag_pkg.sv
// Shared types and constants for the broadcast address generator.
package bag_pkg;

  // Configuration register and result widths
  localparam int REG_W         = 32;
  localparam int ADDR_W        = 32;
  localparam int CFG_IDX_W     = 1;

  // Default geometry
  localparam int MAX_DIMS_DEF  = 4;
  localparam int SIZE_BITS_DEF = 8;

  // Reset value of both size registers: every dimension has size one
  localparam logic [REG_W-1:0] SIZES_RST = 32'h0101_0101;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SIZES_A = 1'b0,
    CFG_SIZES_B = 1'b1
  } bag_cfg_idx_t;

  // Per-dimension status a cell reports to the top level
  typedef struct packed {
    logic              inc;
    logic [ADDR_W-1:0] delta_a;
    logic [ADDR_W-1:0] delta_b;
    logic              bad;
  } bag_cell_st_t;

endpackage

>>> rtl/bag_in_if.sv
// Input channel of the broadcast address generator: one restart/advance item.
interface bag_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

>>> rtl/bag_out_if.sv
// Result channel of the broadcast address generator: one address pair per item.
interface bag_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] out_index;
  logic [31:0] addr_a;
  logic [31:0] addr_b;
  logic        last;
  logic        shape_error;

  modport source (output valid, output out_index, output addr_a, output addr_b,
                  output last, output shape_error, input ready);
  modport sink   (input valid, input out_index, input addr_a, input addr_b,
                  input last, input shape_error, output ready);
endinterface

>>> rtl/broadcast_address_generator.sv
// Top level: broadcast address generator built from a row of dimension cells.
// Each accepted item yields one result: the column-major output index and the
// addresses into operands A and B, with size-one dimensions broadcast (stride
// zero). An item is accepted every cycle while the result register is free or
// being drained; the running addresses advance by one add per item, chosen by
// the dimension cell that increments. After a write to sizes_a or sizes_b the
// strides ripple down the cell row one dimension per cycle, so the input is not
// ready while they settle; the write also restarts the element count.
// Incompatible shapes return shape_error with zero fields and leave the
// counters untouched.
module broadcast_address_generator #(
  parameter int MAX_DIMS  = bag_pkg::MAX_DIMS_DEF,
  parameter int SIZE_BITS = bag_pkg::SIZE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  bag_in_if.sink                       in_ch,
  bag_out_if.source                    out_ch,
  input  logic                         cfg_we,
  input  logic [bag_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bag_pkg::REG_W-1:0]     cfg_data
);
  import bag_pkg::*;

  localparam int SET_W = $clog2(MAX_DIMS + 1);

  logic [REG_W-1:0]  sizes_a_r, sizes_b_r;
  logic [SET_W-1:0]  settle_r, settle_nxt;
  logic [ADDR_W-1:0] stride_a [MAX_DIMS+1];
  logic [ADDR_W-1:0] stride_b [MAX_DIMS+1];
  logic [MAX_DIMS:0] carry;
  bag_cell_st_t      st [MAX_DIMS];
  logic [MAX_DIMS-1:0] inc_vec, bad_vec;

  logic              accept, adv, bad_shape, is_last;
  logic [ADDR_W-1:0] idx_r, addr_a_r, addr_b_r;
  logic [ADDR_W-1:0] idx_eff, addr_a_eff, addr_b_eff;
  logic [ADDR_W-1:0] idx_nxt, addr_a_nxt, addr_b_nxt;
  logic [ADDR_W-1:0] delta_a, delta_b;

  logic              ov_r;
  logic [ADDR_W-1:0] o_idx_r, o_aa_r, o_ab_r;
  logic              o_last_r, o_err_r;

  // Size registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sizes_a_r <= SIZES_RST;
      sizes_b_r <= SIZES_RST;
    end else if (cfg_we) begin
      case (bag_cfg_idx_t'(cfg_index))
        CFG_SIZES_A: sizes_a_r <= cfg_data;
        CFG_SIZES_B: sizes_b_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Hold the input off while strides ripple through the cells
  always_comb begin
    settle_nxt = settle_r;
    if (cfg_we) begin
      settle_nxt = SET_W'(MAX_DIMS - 1);
    end else if (settle_r != '0) begin
      settle_nxt = settle_r - SET_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      settle_r <= '0;
    end else begin
      settle_r <= settle_nxt;
    end
  end

  assign in_ch.ready = (settle_r == '0) && (!ov_r || out_ch.ready);
  assign accept      = in_ch.valid && in_ch.ready;
  assign adv         = accept && !bad_shape;

  // Row of dimension cells
  assign stride_a[0] = ADDR_W'(1);
  assign stride_b[0] = ADDR_W'(1);
  assign carry[0]    = 1'b1;

  for (genvar k = 0; k < MAX_DIMS; k++) begin : g_cell
    bag_cell #(.K(k), .SIZE_BITS(SIZE_BITS)) u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .sizes_a      (sizes_a_r),
      .sizes_b      (sizes_b_r),
      .stride_a_in  (stride_a[k]),
      .stride_b_in  (stride_b[k]),
      .stride_a_out (stride_a[k+1]),
      .stride_b_out (stride_b[k+1]),
      .clr          (cfg_we),
      .zero         (in_ch.restart),
      .adv          (adv),
      .carry_in     (carry[k]),
      .carry_out    (carry[k+1]),
      .st           (st[k])
    );
    assign inc_vec[k] = st[k].inc;
    assign bad_vec[k] = st[k].bad;
  end

  assign bad_shape = |bad_vec;
  assign is_last   = carry[MAX_DIMS];

  // Merge the jump of the one cell that increments
  always_comb begin
    delta_a = '0;
    delta_b = '0;
    for (int k = 0; k < MAX_DIMS; k++) begin
      delta_a = delta_a | st[k].delta_a;
      delta_b = delta_b | st[k].delta_b;
    end
  end

  // Running index and addresses of the current element
  assign idx_eff    = in_ch.restart ? '0 : idx_r;
  assign addr_a_eff = in_ch.restart ? '0 : addr_a_r;
  assign addr_b_eff = in_ch.restart ? '0 : addr_b_r;

  always_comb begin
    idx_nxt    = idx_r;
    addr_a_nxt = addr_a_r;
    addr_b_nxt = addr_b_r;
    if (cfg_we) begin
      idx_nxt    = '0;
      addr_a_nxt = '0;
      addr_b_nxt = '0;
    end else if (adv) begin
      if (is_last) begin
        idx_nxt    = '0;
        addr_a_nxt = '0;
        addr_b_nxt = '0;
      end else begin
        idx_nxt    = idx_eff + ADDR_W'(1);
        addr_a_nxt = addr_a_eff + delta_a;
        addr_b_nxt = addr_b_eff + delta_b;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r    <= '0;
      addr_a_r <= '0;
      addr_b_r <= '0;
    end else begin
      idx_r    <= idx_nxt;
      addr_a_r <= addr_a_nxt;
      addr_b_r <= addr_b_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (accept) begin
      ov_r <= 1'b1;
    end else if (out_ch.ready) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      o_err_r  <= bad_shape;
      o_idx_r  <= bad_shape ? '0 : idx_eff;
      o_aa_r   <= bad_shape ? '0 : addr_a_eff;
      o_ab_r   <= bad_shape ? '0 : addr_b_eff;
      o_last_r <= bad_shape ? 1'b0 : is_last;
    end
  end

  assign out_ch.valid       = ov_r;
  assign out_ch.out_index   = o_idx_r;
  assign out_ch.addr_a      = o_aa_r;
  assign out_ch.addr_b      = o_ab_r;
  assign out_ch.last        = o_last_r;
  assign out_ch.shape_error = o_err_r;

  // No item enters while strides are still settling
  a_settle_block: assert property (@(posedge clk) disable iff (!rst_n)
    (settle_r != '0) |-> !accept)
    else $error("item accepted while strides settle");

  // At most one dimension increments per item
  a_one_inc: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(inc_vec))
    else $error("more than one dimension increments");

  // Wrap and increment are exclusive
  a_last_no_inc: assert property (@(posedge clk) disable iff (!rst_n)
    is_last |-> (inc_vec == '0))
    else $error("increment on the final element");

  // Error results carry zero fields
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && o_err_r) |-> (o_aa_r == '0 && o_ab_r == '0 && o_idx_r == '0 && !o_last_r))
    else $error("shape error result with nonzero fields");

endmodule

>>> rtl/bag_cell.sv
// One dimension cell: size decode, stride register, element counter, carry.
module bag_cell #(
  parameter int K         = 0,
  parameter int SIZE_BITS = bag_pkg::SIZE_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [bag_pkg::REG_W-1:0] sizes_a,
  input  logic [bag_pkg::REG_W-1:0] sizes_b,
  input  logic [bag_pkg::ADDR_W-1:0] stride_a_in,
  input  logic [bag_pkg::ADDR_W-1:0] stride_b_in,
  output logic [bag_pkg::ADDR_W-1:0] stride_a_out,
  output logic [bag_pkg::ADDR_W-1:0] stride_b_out,
  input  logic                     clr,
  input  logic                     zero,
  input  logic                     adv,
  input  logic                     carry_in,
  output logic                     carry_out,
  output bag_pkg::bag_cell_st_t    st
);
  import bag_pkg::*;

  localparam int PAD_W  = REG_W + SIZE_BITS;
  localparam int PROD_W = ADDR_W + SIZE_BITS;
  localparam logic [SIZE_BITS-1:0] ONE = SIZE_BITS'(1);

  logic [SIZE_BITS-1:0] raw_a, raw_b, dim_a, dim_b, out_size;
  logic [SIZE_BITS-1:0] cnt_r, cnt_nxt, cnt_eff;
  logic [ADDR_W-1:0]    stride_a_r, stride_b_r;
  logic [PROD_W-1:0]    prod_a, prod_b;
  logic [ADDR_W-1:0]    jump_a, jump_b;
  logic                 at_max, inc, bad;

  // Pick this dimension's size field; fields above the register read as zero
  generate
    if (K * SIZE_BITS >= REG_W) begin : g_beyond
      assign raw_a = '0;
      assign raw_b = '0;
    end else begin : g_field
      logic [PAD_W-1:0] ext_a, ext_b;
      assign ext_a = {{SIZE_BITS{1'b0}}, sizes_a};
      assign ext_b = {{SIZE_BITS{1'b0}}, sizes_b};
      assign raw_a = ext_a[K*SIZE_BITS +: SIZE_BITS];
      assign raw_b = ext_b[K*SIZE_BITS +: SIZE_BITS];
    end
  endgenerate

  // A size of zero counts as one
  assign dim_a = (raw_a == '0) ? ONE : raw_a;
  assign dim_b = (raw_b == '0) ? ONE : raw_b;

  // Broadcast rule for the output size
  always_comb begin
    bad      = 1'b0;
    out_size = dim_a;
    if (dim_a == dim_b || dim_b == ONE) begin
      out_size = dim_a;
    end else if (dim_a == ONE) begin
      out_size = dim_b;
    end else begin
      out_size = ONE;
      bad      = 1'b1;
    end
  end

  // Stride register takes the neighbor's product every cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stride_a_r <= ADDR_W'(1);
      stride_b_r <= ADDR_W'(1);
    end else begin
      stride_a_r <= stride_a_in;
      stride_b_r <= stride_b_in;
    end
  end

  // Hand the next dimension its stride, modulo 2^32
  assign prod_a = {{SIZE_BITS{1'b0}}, stride_a_r} * {{ADDR_W{1'b0}}, dim_a};
  assign prod_b = {{SIZE_BITS{1'b0}}, stride_b_r} * {{ADDR_W{1'b0}}, dim_b};
  assign stride_a_out = prod_a[ADDR_W-1:0];
  assign stride_b_out = prod_b[ADDR_W-1:0];

  // Counter step: increment when all lower dimensions wrap, wrap at the top
  assign cnt_eff   = zero ? '0 : cnt_r;
  assign at_max    = (cnt_eff == out_size - ONE);
  assign inc       = carry_in & ~at_max;
  assign carry_out = carry_in & at_max;

  always_comb begin
    cnt_nxt = cnt_r;
    if (clr) begin
      cnt_nxt = '0;
    end else if (adv) begin
      if (carry_in) begin
        cnt_nxt = at_max ? '0 : cnt_eff + ONE;
      end else begin
        cnt_nxt = cnt_eff;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // Address step when this dimension increments: lower dimensions span
  // exactly stride - 1, so the jump is 1, or 1 - stride when broadcast
  assign jump_a = !inc ? '0 : (dim_a != ONE) ? ADDR_W'(1) : ADDR_W'(1) - stride_a_r;
  assign jump_b = !inc ? '0 : (dim_b != ONE) ? ADDR_W'(1) : ADDR_W'(1) - stride_b_r;

  assign st = '{inc: inc, delta_a: jump_a, delta_b: jump_b, bad: bad};

endmodule

>>> test/broadcast_address_generator_tb.sv
// Self-checking testbench for the broadcast address generator: directed shapes, random ones, then an output stall.
module broadcast_address_generator_tb;
  import bag_pkg::*;

  localparam int MAX_DIMS   = MAX_DIMS_DEF;
  localparam int SIZE_BITS  = SIZE_BITS_DEF;
  localparam int RAND_ITEMS = 470;
  localparam int IDLE_LIMIT = 1500;
  localparam int LONG_HOLD  = 250;

  // One expected result item
  typedef struct {
    logic [ADDR_W-1:0] index;
    logic [ADDR_W-1:0] addr_a;
    logic [ADDR_W-1:0] addr_b;
    logic              last;
    logic              shape_error;
  } addr_result_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [REG_W-1:0] cfg_data;

  bag_in_if  in_ch ();
  bag_out_if out_ch ();

  broadcast_address_generator i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Shadow geometry and counters of the block
  logic [REG_W-1:0]  shadow_sizes_a;
  logic [REG_W-1:0]  shadow_sizes_b;
  logic [ADDR_W-1:0] dim_len_a  [MAX_DIMS];
  logic [ADDR_W-1:0] dim_len_b  [MAX_DIMS];
  logic [ADDR_W-1:0] result_len [MAX_DIMS];
  logic [ADDR_W-1:0] step_a     [MAX_DIMS];
  logic [ADDR_W-1:0] step_b     [MAX_DIMS];
  logic [ADDR_W-1:0] position   [MAX_DIMS];
  logic [ADDR_W-1:0] element_idx;
  logic              shapes_clash;

  addr_result_t pending_addrs [$];
  int unsigned  error_count;
  int unsigned  burst_left;
  bit           long_hold_req;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Size of one dimension: a zero field and a field above the register read as one
  function automatic logic [ADDR_W-1:0] size_of_dim(logic [REG_W-1:0] word, int k);
    logic [REG_W-1:0] v;
    if (k * SIZE_BITS >= REG_W) return 1;
    v = (word >> (k * SIZE_BITS)) & ((32'd1 << SIZE_BITS) - 1);
    return (v == 0) ? 32'd1 : v;
  endfunction

  // Recompute output sizes and strides, clear the counters
  function automatic void rebuild_geometry();
    shapes_clash = 1'b0;
    for (int k = 0; k < MAX_DIMS; k++) begin
      dim_len_a[k] = size_of_dim(shadow_sizes_a, k);
      dim_len_b[k] = size_of_dim(shadow_sizes_b, k);
      if (dim_len_a[k] == dim_len_b[k] || dim_len_b[k] == 1) begin
        result_len[k] = dim_len_a[k];
      end else if (dim_len_a[k] == 1) begin
        result_len[k] = dim_len_b[k];
      end else begin
        result_len[k] = 1;
        shapes_clash  = 1'b1;
      end
      if (k == 0) begin
        step_a[k] = 1;
        step_b[k] = 1;
      end else begin
        step_a[k] = step_a[k-1] * dim_len_a[k-1];
        step_b[k] = step_b[k-1] * dim_len_b[k-1];
      end
      position[k] = 0;
    end
    element_idx = 0;
  endfunction

  function automatic void apply_sizes(bag_cfg_idx_t idx, logic [REG_W-1:0] value);
    case (idx)
      CFG_SIZES_A: shadow_sizes_a = value;
      CFG_SIZES_B: shadow_sizes_b = value;
      default: return;
    endcase
    rebuild_geometry();
  endfunction

  // Work out the result of one accepted item and queue it
  function automatic void predict_addresses(logic restart);
    addr_result_t r;
    logic [ADDR_W-1:0] aa;
    logic [ADDR_W-1:0] ab;
    logic is_last;
    aa = 0;
    ab = 0;
    is_last = 1'b1;
    if (shapes_clash) begin
      r = '{index: '0, addr_a: '0, addr_b: '0, last: 1'b0, shape_error: 1'b1};
      pending_addrs.push_back(r);
      return;
    end
    if (restart) begin
      for (int k = 0; k < MAX_DIMS; k++) position[k] = 0;
      element_idx = 0;
    end
    for (int k = 0; k < MAX_DIMS; k++) begin
      if (dim_len_a[k] != 1) aa += step_a[k] * position[k];
      if (dim_len_b[k] != 1) ab += step_b[k] * position[k];
      if (position[k] + 1 != result_len[k]) is_last = 1'b0;
    end
    r = '{index: element_idx, addr_a: aa, addr_b: ab, last: is_last, shape_error: 1'b0};
    pending_addrs.push_back(r);
    if (is_last) begin
      for (int k = 0; k < MAX_DIMS; k++) position[k] = 0;
      element_idx = 0;
    end else begin
      element_idx++;
      for (int k = 0; k < MAX_DIMS; k++) begin
        if (position[k] + 1 < result_len[k]) begin
          position[k]++;
          break;
        end
        position[k] = 0;
      end
    end
  endfunction

  // Drop valid and wait a number of cycles
  task automatic hold_input(int unsigned cycles);
    in_ch.valid   <= 1'b0;
    in_ch.restart <= 1'($urandom_range(0, 1));
    repeat (cycles) @(posedge clk);
  endtask

  // Offer one item and wait for the handshake
  task automatic send_item(logic restart);
    in_ch.valid   <= 1'b1;
    in_ch.restart <= restart;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    predict_addresses(restart);
  endtask

  // Send items in bursts of random length with random gaps in between
  task automatic send_stream(int unsigned count, int unsigned restart_odds);
    for (int unsigned i = 0; i < count; i++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        if ($urandom_range(0, 3) != 0) hold_input($urandom_range(1, 6));
      end
      burst_left--;
      send_item(restart_odds != 0 && $urandom_range(1, restart_odds) == 1);
    end
  endtask

  // Write one size register once the block has drained
  task automatic write_sizes(bag_cfg_idx_t idx, logic [REG_W-1:0] value);
    in_ch.valid <= 1'b0;
    while (pending_addrs.size() != 0) @(posedge clk);
    repeat (MAX_DIMS) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cfg_data  <= $urandom();
    apply_sizes(idx, value);
  endtask

  task automatic set_shapes(logic [REG_W-1:0] a_word, logic [REG_W-1:0] b_word);
    if ($urandom_range(0, 1) == 1) begin
      write_sizes(CFG_SIZES_A, a_word);
      write_sizes(CFG_SIZES_B, b_word);
    end else begin
      write_sizes(CFG_SIZES_B, b_word);
      write_sizes(CFG_SIZES_A, a_word);
    end
  endtask

  // Pick a pair of shapes: mostly small and compatible, sometimes long or clashing
  task automatic pick_shapes(output logic [REG_W-1:0] a_word, output logic [REG_W-1:0] b_word);
    int unsigned mode;
    int unsigned budget;
    int unsigned s;
    int unsigned k;
    mode   = $urandom_range(0, 9);
    a_word = '0;
    b_word = '0;
    if (mode == 0) begin
      a_word = $urandom();
      b_word = $urandom();
    end else if (mode == 1) begin
      k = $urandom_range(0, MAX_DIMS - 1);
      s = $urandom_range(100, 255);
      a_word[k*SIZE_BITS +: SIZE_BITS] = SIZE_BITS'(($urandom_range(0, 2) == 0) ? 1 : s);
      b_word[k*SIZE_BITS +: SIZE_BITS] = SIZE_BITS'(($urandom_range(0, 2) == 0) ? 0 : s);
    end else begin
      budget = 48;
      for (int d = 0; d < MAX_DIMS; d++) begin
        s = $urandom_range(1, 4);
        if (s > budget) s = 1;
        budget = budget / s;
        a_word[d*SIZE_BITS +: SIZE_BITS] = SIZE_BITS'(s);
        b_word[d*SIZE_BITS +: SIZE_BITS] = SIZE_BITS'(s);
        // stretch one side now and then, as a one or as a zero field
        case ($urandom_range(0, 3))
          0: a_word[d*SIZE_BITS +: SIZE_BITS] = SIZE_BITS'($urandom_range(0, 1));
          1: b_word[d*SIZE_BITS +: SIZE_BITS] = SIZE_BITS'($urandom_range(0, 1));
          default: ;
        endcase
      end
      if (mode == 9) begin
        k = $urandom_range(0, MAX_DIMS - 1);
        a_word[k*SIZE_BITS +: SIZE_BITS] = SIZE_BITS'(2);
        b_word[k*SIZE_BITS +: SIZE_BITS] = SIZE_BITS'(3);
      end
    end
  endtask

  // Every dimension of size one: each item is the last one
  task automatic test_reset_shape();
    send_item(1'b0);
    send_item(1'b1);
    send_item(1'b0);
  endtask

  // A stretched in dimension 1, B stretched in dimension 0, with a wrap
  task automatic test_broadcast_dims();
    set_shapes(32'h0000_0102, 32'h0000_0301);
    repeat (7) send_item(1'b0);
  endtask

  // Zero size fields count as one
  task automatic test_zero_fields();
    set_shapes(32'h0000_0000, 32'h0000_0300);
    repeat (3) send_item(1'b0);
  endtask

  // Clashing sizes, then a restart in the middle of a valid shape
  task automatic test_shape_mismatch();
    set_shapes(32'h0000_0002, 32'h0000_0003);
    send_item(1'b0);
    send_item(1'b1);
    set_shapes(32'h0000_0003, 32'h0000_0001);
    send_item(1'b0);
    send_item(1'b0);
    send_item(1'b1);
    send_item(1'b0);
  endtask

  // Largest sizes in every field and in single fields
  task automatic test_extreme_sizes();
    set_shapes(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    repeat (3) send_item(1'b0);
    set_shapes(32'hFF00_0000, 32'h0000_0000);
    repeat (2) send_item(1'b0);
    set_shapes(32'h0000_00FF, 32'hFF00_00FF);
    repeat (2) send_item(1'b0);
  endtask

  task automatic test_random_shapes();
    logic [REG_W-1:0] a_word;
    logic [REG_W-1:0] b_word;
    int unsigned sent;
    int unsigned n;
    sent = 0;
    while (sent < RAND_ITEMS) begin
      pick_shapes(a_word, b_word);
      set_shapes(a_word, b_word);
      n = $urandom_range(10, 40);
      send_stream(n, 12);
      sent += n;
    end
  endtask

  // Hold off the receiver for a long stretch while items keep coming
  task automatic test_output_stall();
    set_shapes(32'h0000_0505, 32'h0000_0105);
    long_hold_req = 1'b1;
    repeat (40) send_item(1'b0);
  endtask

  // Receiver: check each result, then pick ready for the next cycle
  initial begin
    int unsigned cycle_cnt;
    int unsigned stall_mode;
    int unsigned hold_left;
    addr_result_t exp_r;
    cycle_cnt    = 0;
    stall_mode   = 0;
    hold_left    = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        if (pending_addrs.size() == 0) begin
          $error("result item with nothing expected: index %0d", out_ch.out_index);
          error_count++;
        end else begin
          exp_r = pending_addrs.pop_front();
          if (out_ch.out_index !== exp_r.index) begin
            $error("out_index: expected %0d, got %0d", exp_r.index, out_ch.out_index);
            error_count++;
          end
          if (out_ch.addr_a !== exp_r.addr_a) begin
            $error("addr_a: expected %0d, got %0d", exp_r.addr_a, out_ch.addr_a);
            error_count++;
          end
          if (out_ch.addr_b !== exp_r.addr_b) begin
            $error("addr_b: expected %0d, got %0d", exp_r.addr_b, out_ch.addr_b);
            error_count++;
          end
          if (out_ch.last !== exp_r.last) begin
            $error("last: expected %0b, got %0b", exp_r.last, out_ch.last);
            error_count++;
          end
          if (out_ch.shape_error !== exp_r.shape_error) begin
            $error("shape_error: expected %0b, got %0b", exp_r.shape_error, out_ch.shape_error);
            error_count++;
          end
        end
      end
      // count cycles and pick a new random stall pattern periodically
      cycle_cnt++;
      if (cycle_cnt % 50 == 0) stall_mode = $urandom_range(0, 3);
      if (long_hold_req && hold_left == 0) begin
        hold_left     = LONG_HOLD;
        long_hold_req = 1'b0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        case (stall_mode)
          0: out_ch.ready <= 1'b1;
          1: out_ch.ready <= 1'($urandom_range(0, 1));
          2: out_ch.ready <= ($urandom_range(0, 3) != 0);
          default: out_ch.ready <= (cycle_cnt % 8 < 5);
        endcase
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  initial begin
    int unsigned quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
          (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) || cfg_we === 1'b1) begin
        quiet = 0;
      end else begin
        quiet++;
      end
      if (quiet >= IDLE_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // Main sequence
  initial begin
    error_count   = 0;
    burst_left    = 0;
    long_hold_req = 1'b0;
    shadow_sizes_a = SIZES_RST;
    shadow_sizes_b = SIZES_RST;
    rebuild_geometry();
    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.restart <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_index     <= CFG_SIZES_A;
    cfg_data      <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_shape();
    test_broadcast_dims();
    test_zero_fields();
    test_shape_mismatch();
    test_extreme_sizes();
    test_random_shapes();
    test_output_stall();

    // drain, then let the pipeline settle
    hold_input(1);
    while (pending_addrs.size() != 0) @(posedge clk);
    repeat (MAX_DIMS + 4) @(posedge clk);
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/bag_pkg.sv
rtl/bag_in_if.sv
rtl/bag_out_if.sv
rtl/bag_cell.sv
rtl/broadcast_address_generator.sv
test/broadcast_address_generator_tb.sv
